// ===== hw/rtl/bsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the barometric compensation block
// Holds the payload structs, the register indexes and the fixed-point constants.
// ----------------------------------------------------------------------------
package bsc_pkg;

    typedef struct packed {
        logic [19:0] adc_temperature;
        logic [19:0] adc_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic        [31:0] pressure_pa;
        logic               pressure_invalid;
    } t_out_item;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_MID  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_HIGH = 2'd3;

    localparam logic [31:0] FINE_OFFSET = 32'd64000;
    localparam logic [31:0] P_BASE      = 32'd1048576;
    localparam logic [31:0] P_SCALE     = 32'd3125;
    localparam logic [31:0] DIV_BASE    = 32'd32768;
    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [31:0] ROUND_HALF  = 32'd128;

    localparam int DIV_STEPS = 32;

    // Sign-extend a 16-bit calibration word to 32 bits.
    function automatic logic [31:0] sx16(input logic [15:0] w);
        sx16 = {{16{w[15]}}, w};
    endfunction

    // Low 32 bits of a product.
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        mul32 = p[31:0];
    endfunction

    // Arithmetic right shift of a 32-bit pattern, kept self-contained so that
    // the sign fill survives when the result is mixed with unsigned terms.
    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        asr32 = $unsigned($signed(x) >>> n);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bsc_div_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_div_stage: one registered step of the unsigned restoring divider
// Takes one quotient bit per stage; side data rides along with the valid bit.
// ----------------------------------------------------------------------------
module bsc_div_stage #(
    parameter int SIDE_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_rem,
    input  wire logic [31:0]       i_num,
    input  wire logic [31:0]       i_quo,
    input  wire logic [31:0]       i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [31:0]            o_rem,
    output logic [31:0]            o_num,
    output logic [31:0]            o_quo,
    output logic [31:0]            o_den,
    output logic [SIDE_W-1:0]      o_side
);
    logic [32:0] n_trial;
    logic [32:0] n_diff;

    always_comb begin
        n_trial = {i_rem, i_num[31]};
        n_diff  = n_trial - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_num  <= {i_num[30:0], 1'b0};
        o_den  <= i_den;
        o_side <= i_side;
        if (!n_diff[32]) begin
            o_rem <= n_diff[31:0];
            o_quo <= {i_quo[30:0], 1'b1};
        end else begin
            o_rem <= n_trial[31:0];
            o_quo <= {i_quo[30:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/baro_sensor_compensation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// baro_sensor_compensation: pipelined 32-bit fixed-point pressure/temperature
// compensation for a barometric sensor
//
// Channel   Direction  Transfer when            Payload
// input     in         i_start & !o_busy        i_item (t_in_item)
// result    out        o_done (one cycle)       o_result (t_out_item)
// config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// One item may enter every cycle; o_busy is held low. The pipe has
// 12 front stages, 32 divider stages and 6 tail stages. The divider,
// one quotient bit per stage, sets the depth. Each result is shown for one
// cycle with o_done; the receiver cannot stall, so nothing in the pipe ever
// waits. Synchronous reset clears the valid bits and the calibration words.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire bsc_pkg::t_in_item                 i_item,
    output logic                                   o_done,
    output bsc_pkg::t_out_item                     o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bsc_pkg::*;

    // Calibration registers.
    logic [47:0] r_tcal;
    logic [63:0] r_plow, r_pmid;
    logic [15:0] r_phigh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal <= '0; r_plow <= '0; r_pmid <= '0; r_phigh <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TEMP_CAL:  r_tcal  <= i_cfg_data[47:0];
                REG_PRES_LOW:  r_plow  <= i_cfg_data;
                REG_PRES_MID:  r_pmid  <= i_cfg_data;
                REG_PRES_HIGH: r_phigh <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_tcal[15:0]};
    assign t2 = sx16(r_tcal[31:16]);
    assign t3 = sx16(r_tcal[47:32]);
    assign p1 = {16'd0, r_plow[15:0]};
    assign p2 = sx16(r_plow[31:16]);
    assign p3 = sx16(r_plow[47:32]);
    assign p4 = sx16(r_plow[63:48]);
    assign p5 = sx16(r_pmid[15:0]);
    assign p6 = sx16(r_pmid[31:16]);
    assign p7 = sx16(r_pmid[47:32]);
    assign p8 = sx16(r_pmid[63:48]);
    assign p9 = sx16(r_phigh);

    assign o_busy = 1'b0;

    // Pipeline valid bits for the front stages.
    logic [11:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[10:0], i_start};
    end

    // Stage 1: products for the fine temperature.
    logic [31:0] r1_ma, r1_dd, r1_adcp;
    logic [31:0] adc_t;
    assign adc_t = {12'd0, i_item.adc_temperature};
    always_ff @(posedge i_clk) begin
        r1_ma   <= mul32((adc_t >> 3) - (t1 << 1), t2);
        r1_dd   <= mul32((adc_t >> 4) - t1, (adc_t >> 4) - t1);
        r1_adcp <= {12'd0, i_item.adc_pressure};
    end

    // Stage 2.
    logic [31:0] r2_a, r2_db, r2_adcp;
    always_ff @(posedge i_clk) begin
        r2_a    <= $signed(r1_ma) >>> 11;
        r2_db   <= mul32($signed(r1_dd) >>> 12, t3);
        r2_adcp <= r1_adcp;
    end

    // Stage 3: fine temperature.
    logic [31:0] r3_fine, r3_adcp;
    always_ff @(posedge i_clk) begin
        r3_fine <= r2_a + asr32(r2_db, 14);
        r3_adcp <= r2_adcp;
    end

    // Stage 4: temperature product, first pressure terms.
    logic [31:0] r4_t5, r4_a, r4_q, r4_adcp;
    logic [31:0] s4_a;
    assign s4_a = asr32(r3_fine, 1) - FINE_OFFSET;
    always_ff @(posedge i_clk) begin
        r4_t5   <= mul32(r3_fine, 32'd5);
        r4_a    <= s4_a;
        r4_q    <= $signed(s4_a) >>> 2;
        r4_adcp <= r3_adcp;
    end

    // Stage 5: temperature result, square.
    logic [31:0] r5_temp, r5_a, r5_sq, r5_adcp;
    always_ff @(posedge i_clk) begin
        r5_temp <= $signed(r4_t5 + ROUND_HALF) >>> 8;
        r5_a    <= r4_a;
        r5_sq   <= mul32(r4_q, r4_q);
        r5_adcp <= r4_adcp;
    end

    // Stage 6: four independent products.
    logic [31:0] r6_temp, r6_b6, r6_b5, r6_a3, r6_a2, r6_adcp;
    always_ff @(posedge i_clk) begin
        r6_temp <= r5_temp;
        r6_b6   <= mul32($signed(r5_sq) >>> 11, p6);
        r6_b5   <= mul32(r5_a, p5);
        r6_a3   <= mul32(p3, $signed(r5_sq) >>> 13);
        r6_a2   <= mul32(p2, r5_a);
        r6_adcp <= r5_adcp;
    end

    // Stage 7: sums.
    logic [31:0] r7_temp, r7_b, r7_a, r7_adcp;
    logic [31:0] s7_b;
    assign s7_b = r6_b6 + (r6_b5 << 1);
    always_ff @(posedge i_clk) begin
        r7_temp <= r6_temp;
        r7_b    <= asr32(s7_b, 2) + (p4 << 16);
        r7_a    <= $signed(($signed(r6_a3) >>> 3) + ($signed(r6_a2) >>> 1)) >>> 18;
        r7_adcp <= r6_adcp;
    end

    // Stage 8: divisor product and numerator base.
    logic [31:0] r8_temp, r8_dm, r8_pn;
    always_ff @(posedge i_clk) begin
        r8_temp <= r7_temp;
        r8_dm   <= mul32(DIV_BASE + r7_a, p1);
        r8_pn   <= (P_BASE - r7_adcp) - asr32(r7_b, 12);
    end

    // Stage 9: scale numerator, finish divisor.
    logic [31:0] r9_temp, r9_div, r9_p;
    always_ff @(posedge i_clk) begin
        r9_temp <= r8_temp;
        r9_div  <= $signed(r8_dm) >>> 15;
        r9_p    <= mul32(r8_pn, P_SCALE);
    end

    // Stage 10: choose dividend; a zero divisor is replaced by one and flagged.
    logic [31:0] r10_temp, r10_num, r10_den;
    logic        r10_inv, r10_hi;
    always_ff @(posedge i_clk) begin
        r10_temp <= r9_temp;
        r10_inv  <= (r9_div == 32'd0);
        r10_den  <= (r9_div == 32'd0) ? 32'd1 : r9_div;
        r10_hi   <= (r9_p >= SIGN_BIT);
        r10_num  <= (r9_p >= SIGN_BIT) ? r9_p : (r9_p << 1);
    end

    // Padding stages keep the front at 12 stages.
    logic [31:0] r11_temp, r11_num, r11_den;
    logic        r11_inv, r11_hi;
    always_ff @(posedge i_clk) begin
        r11_temp <= r10_temp; r11_num <= r10_num; r11_den <= r10_den;
        r11_inv  <= r10_inv;  r11_hi  <= r10_hi;
    end
    logic [31:0] r12_temp, r12_num, r12_den;
    logic        r12_inv, r12_hi;
    always_ff @(posedge i_clk) begin
        r12_temp <= r11_temp; r12_num <= r11_num; r12_den <= r11_den;
        r12_inv  <= r11_inv;  r12_hi  <= r11_hi;
    end

    // Divider chain, one quotient bit per stage.
    localparam int SIDE_W = 34;
    logic                dv_v    [DIV_STEPS+1];
    logic [31:0]         dv_rem  [DIV_STEPS+1];
    logic [31:0]         dv_num  [DIV_STEPS+1];
    logic [31:0]         dv_quo  [DIV_STEPS+1];
    logic [31:0]         dv_den  [DIV_STEPS+1];
    logic [SIDE_W-1:0]   dv_side [DIV_STEPS+1];

    assign dv_v[0]    = r_v[11];
    assign dv_rem[0]  = '0;
    assign dv_num[0]  = r12_num;
    assign dv_quo[0]  = '0;
    assign dv_den[0]  = r12_den;
    assign dv_side[0] = {r12_temp, r12_inv, r12_hi};

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        bsc_div_stage #(.SIDE_W(SIDE_W)) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(dv_v[g]),
            .i_rem  (dv_rem[g]),
            .i_num  (dv_num[g]),
            .i_quo  (dv_quo[g]),
            .i_den  (dv_den[g]),
            .i_side (dv_side[g]),
            .o_valid(dv_v[g+1]),
            .o_rem  (dv_rem[g+1]),
            .o_num  (dv_num[g+1]),
            .o_quo  (dv_quo[g+1]),
            .o_den  (dv_den[g+1]),
            .o_side (dv_side[g+1])
        );
    end

    // Tail: correction with P7, P8, P9.
    logic [31:0] sd_temp, sd_q;
    logic        sd_inv, sd_hi;
    assign sd_temp = dv_side[DIV_STEPS][33:2];
    assign sd_inv  = dv_side[DIV_STEPS][1];
    assign sd_hi   = dv_side[DIV_STEPS][0];
    assign sd_q    = dv_quo[DIV_STEPS];

    logic [4:0] r_tv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tv <= '0;
        else          r_tv <= {r_tv[3:0], dv_v[DIV_STEPS]};
    end

    // T1: quotient, squared operand.
    logic [31:0] rt1_temp, rt1_p, rt1_p3;
    logic        rt1_inv;
    always_ff @(posedge i_clk) begin
        rt1_temp <= sd_temp;
        rt1_inv  <= sd_inv;
        rt1_p    <= sd_inv ? 32'd0 : (sd_hi ? (sd_q << 1) : sd_q);
        rt1_p3   <= sd_inv ? 32'd0 : ((sd_hi ? (sd_q << 1) : sd_q) >> 3);
    end

    // T2: square and P8 product.
    logic [31:0] rt2_temp, rt2_p, rt2_sq, rt2_b;
    logic        rt2_inv;
    always_ff @(posedge i_clk) begin
        rt2_temp <= rt1_temp; rt2_inv <= rt1_inv; rt2_p <= rt1_p;
        rt2_sq   <= mul32(rt1_p3, rt1_p3);
        rt2_b    <= mul32(rt1_p >> 2, p8);
    end

    // T3: P9 product.
    logic [31:0] rt3_temp, rt3_p, rt3_a9, rt3_b;
    logic        rt3_inv;
    always_ff @(posedge i_clk) begin
        rt3_temp <= rt2_temp; rt3_inv <= rt2_inv; rt3_p <= rt2_p;
        rt3_a9   <= mul32(p9, rt2_sq >> 13);
        rt3_b    <= $signed(rt2_b) >>> 13;
    end

    // T4: sum of corrections.
    logic [31:0] rt4_temp, rt4_p, rt4_s;
    logic        rt4_inv;
    always_ff @(posedge i_clk) begin
        rt4_temp <= rt3_temp; rt4_inv <= rt3_inv; rt4_p <= rt3_p;
        rt4_s    <= asr32(rt3_a9, 12) + rt3_b + p7;
    end

    // T5: final pressure.
    logic [31:0] rt5_temp, rt5_p;
    logic        rt5_inv;
    always_ff @(posedge i_clk) begin
        rt5_temp <= rt4_temp; rt5_inv <= rt4_inv;
        rt5_p    <= rt4_inv ? 32'd0 : rt4_p + asr32(rt4_s, 4);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_tv[4];
        end
        o_result.temperature_centi <= rt5_temp;
        o_result.pressure_pa       <= rt5_p;
        o_result.pressure_invalid  <= rt5_inv;
    end
endmodule
`default_nettype wire
